[sv/c_escape_encoder_assert.svh]
// assertion macros shared by the c_escape_encoder checker
// no dependencies; include by bare file name
`ifndef C_ESCAPE_ENCODER_ASSERT_SVH
`define C_ESCAPE_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CESC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c_escape_encoder check failed");

// next-cycle implication, sampled on clk, off during reset
`define CESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c_escape_encoder check failed");

`endif

[sv/cesc_pkg.sv]
// shared types, constants and the byte classifier of the c escape encoder
// no dependencies
`default_nettype none

package cesc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_RUN     = 4;

  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_V       = 8'h76;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_R       = 8'h72;

  // one escaped run: up to four characters and the index of the last one
  typedef struct packed {
    logic [$clog2(MAX_RUN)-1:0]  last_idx;
    logic [MAX_RUN-1:0][7:0]     chars;
  } run_t;

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {4'd0, d};
    end else begin
      res = CH_LOWER_A + {4'd0, d} - 8'd10;
    end
    return res;
  endfunction

  // turn a raw byte into its escaped run
  function automatic run_t classify(input logic [7:0] b);
    run_t r;
    r = '0;
    r.chars[0] = CH_BSLASH;
    r.last_idx = 2'd1;
    unique case (b)
      8'd0:  r.chars[1] = CH_ZERO;
      8'd7:  r.chars[1] = CH_A;
      8'd8:  r.chars[1] = CH_B;
      8'd9:  r.chars[1] = CH_T;
      8'd10: r.chars[1] = CH_N;
      8'd11: r.chars[1] = CH_V;
      8'd12: r.chars[1] = CH_F;
      8'd13: r.chars[1] = CH_R;
      8'd34, 8'd39, 8'd92: r.chars[1] = b;
      default: begin
        if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
          // printable passes as a single character
          r.chars[0] = b;
          r.last_idx = 2'd0;
        end else if (b >= 8'd16) begin
          r.chars[1] = CH_X;
          r.chars[2] = hex_char(b[7:4]);
          r.chars[3] = hex_char(b[3:0]);
          r.last_idx = 2'd3;
        end else begin
          r.chars[1] = CH_X;
          r.chars[2] = hex_char(b[3:0]);
          r.last_idx = 2'd2;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/cesc_front.sv]
// front stage: accepts raw bytes and classifies them into escaped runs
// depends on cesc_pkg
`default_nettype none

module cesc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  output logic               push_valid,
  input  wire logic          push_ready,
  output cesc_pkg::run_t     push_data
);

  logic           vld_r;
  logic           vld_nxt;
  cesc_pkg::run_t run_r;

  // stage frees when empty or when its word moves into the queue
  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_data  = run_r;
  assign vld_nxt    = in_ready ? in_valid : vld_r;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // classified run
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      run_r <= cesc_pkg::classify(in_byte);
    end
  end

endmodule

`default_nettype wire

[sv/cesc_fifo.sv]
// short queue of classified runs between front and back
// depends on cesc_pkg
`default_nettype none

module cesc_fifo #(
  parameter int unsigned DEPTH = cesc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  cesc_pkg::run_t     push_data,
  output logic               pop_valid,
  input  wire logic          pop,
  output cesc_pkg::run_t     pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cesc_pkg::run_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/cesc_back.sv]
// back stage: walks each queued run one character per cycle, when not stalled, into the output register
// depends on cesc_pkg
`default_nettype none

module cesc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  cesc_pkg::run_t     head_data,
  output logic               head_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_run_last
);

  localparam int unsigned IW = $clog2(cesc_pkg::MAX_RUN);

  logic          out_vld_r, out_vld_nxt;
  logic [7:0]    byte_r;
  logic          last_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          load;
  logic          at_last;

  assign load     = head_valid && (!out_vld_r || out_ready);
  assign at_last  = (idx_r == head_data.last_idx);
  assign head_pop = load && at_last;

  assign out_valid    = out_vld_r;
  assign out_byte     = byte_r;
  assign out_run_last = last_r;

  // character index and output valid
  always_comb begin
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r;
    if (load) begin
      idx_nxt     = at_last ? '0 : idx_r + 1'b1;
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_data.chars[idx_r];
      last_r <= at_last;
    end
  end

endmodule

`default_nettype wire

[sv/c_escape_encoder.sv]
// The first character of a run passes the front register, a queue entry and the
// output register. Each byte becomes a run of one to four escaped characters, and
// the single output register emits one character a cycle while out_ready allows.
// Reset: synchronous active-low rst_n clears front valid, queue pointers,
// character index and output valid; no clearing pass.
// top level: front classifier, run queue and back emitter; depends on cesc_pkg
`default_nettype none

module c_escape_encoder #(
  parameter int unsigned QUEUE_DEPTH = cesc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);

  logic           push_valid, push_ready;
  cesc_pkg::run_t push_data;
  logic           head_valid, head_pop;
  cesc_pkg::run_t head_data;

  // classify incoming bytes
  cesc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouple front from back
  cesc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_data   (head_data)
  );

  // emit escaped characters
  cesc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .head_pop     (head_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire

[sv/cesc_checker.sv]
// port-level checks for c_escape_encoder, bound to the top level
// depends on c_escape_encoder_assert.svh and cesc_pkg
`default_nettype none

`include "c_escape_encoder_assert.svh"

module cesc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last
);

  logic       out_stall;
  logic       in_stall;
  logic [8:0] out_word;
  logic       nonlast_ok;

  assign out_stall = out_valid && !out_ready;
  assign in_stall  = in_valid && !in_ready;
  assign out_word  = {out_byte, out_run_last};

  // backslash, x, decimal digit or lowercase hex letter
  assign nonlast_ok =
    (out_byte == cesc_pkg::CH_BSLASH) || (out_byte == cesc_pkg::CH_X) ||
    (out_byte >= cesc_pkg::CH_ZERO && out_byte < cesc_pkg::CH_ZERO + 8'd10) ||
    (out_byte >= cesc_pkg::CH_LOWER_A && out_byte < cesc_pkg::CH_LOWER_A + 8'd6);

  // stalled output word holds
  `CESC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word))

  // stalled input word holds
  `CESC_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_byte))

  // a character that is not the last of its run is a backslash, an x or a hex digit
  `CESC_ASSERT_NOW(a_nonlast_charset, out_valid && !out_run_last, nonlast_ok)

  // nothing comes out right after reset
  `CESC_ASSERT_NOW(a_idle_after_reset, $past(!rst_n), !out_valid)

endmodule

bind c_escape_encoder cesc_checker u_cesc_checker (.*);

`default_nettype wire

[verif/c_escape_encoder_tb.sv]
// self-checking testbench for c_escape_encoder: random and directed raw bytes
// checked word by word against an escape-run predictor; depends only on the rtl
module c_escape_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT       = 12;
  localparam int RANDOM_ITEMS   = 155;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;

  // raw bytes with a two-character escape, and the printable range bounds
  localparam logic [7:0] RAW_NUL     = 8'd0;
  localparam logic [7:0] RAW_BEL     = 8'd7;
  localparam logic [7:0] RAW_BS      = 8'd8;
  localparam logic [7:0] RAW_TAB     = 8'd9;
  localparam logic [7:0] RAW_LF      = 8'd10;
  localparam logic [7:0] RAW_VT      = 8'd11;
  localparam logic [7:0] RAW_FF      = 8'd12;
  localparam logic [7:0] RAW_CR      = 8'd13;
  localparam logic [7:0] RAW_DQUOTE  = 8'd34;
  localparam logic [7:0] RAW_SQUOTE  = 8'd39;
  localparam logic [7:0] RAW_BSLASH  = 8'd92;
  localparam logic [7:0] PRINT_FIRST = 8'd32;
  localparam logic [7:0] PRINT_LAST  = 8'd126;

  // ascii characters of the escaped form
  localparam logic [7:0] ASC_BSLASH = 8'h5C;
  localparam logic [7:0] ASC_ZERO   = "0";
  localparam logic [7:0] ASC_A      = "a";
  localparam logic [7:0] ASC_B      = "b";
  localparam logic [7:0] ASC_T      = "t";
  localparam logic [7:0] ASC_N      = "n";
  localparam logic [7:0] ASC_V      = "v";
  localparam logic [7:0] ASC_F      = "f";
  localparam logic [7:0] ASC_R      = "r";
  localparam logic [7:0] ASC_X      = "x";

  typedef struct {
    logic [7:0] raw;
    bit         wait_empty;
  } raw_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } esc_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_run_last;

  raw_item_t raw_bytes_q [$];
  esc_char_t escape_chars_q [$];
  int        bytes_taken = 0;
  int        error_count = 0;
  int        quiet_cycles = 0;
  logic      steady;

  c_escape_encoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  always #6 clk = ~clk;

  // no idling on either side across this stretch of bytes
  assign steady = (bytes_taken >= 70) && (bytes_taken < 120);

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? ASC_ZERO + {4'd0, nib} : ASC_A + {4'd0, nib} - 8'd10;
  endfunction

  // expected escape run of one raw byte, appended to the expectation queue
  task automatic push_escape_run(input logic [7:0] raw);
    logic [7:0] run_chars [4];
    int         run_len;
    run_chars[0] = ASC_BSLASH;
    run_len = 2;
    case (raw)
      RAW_NUL: run_chars[1] = ASC_ZERO;
      RAW_BEL: run_chars[1] = ASC_A;
      RAW_BS:  run_chars[1] = ASC_B;
      RAW_TAB: run_chars[1] = ASC_T;
      RAW_LF:  run_chars[1] = ASC_N;
      RAW_VT:  run_chars[1] = ASC_V;
      RAW_FF:  run_chars[1] = ASC_F;
      RAW_CR:  run_chars[1] = ASC_R;
      RAW_DQUOTE, RAW_SQUOTE, RAW_BSLASH: run_chars[1] = raw;
      default: begin
        if (raw >= PRINT_FIRST && raw <= PRINT_LAST) begin
          run_chars[0] = raw;
          run_len = 1;
        end else if (raw >= 8'd16) begin
          // two hex digits, unsigned
          run_chars[1] = ASC_X;
          run_chars[2] = hex_ascii(raw[7:4]);
          run_chars[3] = hex_ascii(raw[3:0]);
          run_len = 4;
        end else begin
          // single hex digit, no leading zero
          run_chars[1] = ASC_X;
          run_chars[2] = hex_ascii(raw[3:0]);
          run_len = 3;
        end
      end
    endcase
    for (int k = 0; k < run_len; k++) begin
      escape_chars_q.insert(escape_chars_q.size(),
                            '{ch: run_chars[k], last: (k == run_len - 1)});
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // driver: presents queued raw bytes, records the expected run on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        push_escape_run(in_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (raw_bytes_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT) &&
            !(raw_bytes_q[0].wait_empty && escape_chars_q.size() != 0)) begin
          in_valid <= 1'b1;
          in_byte  <= raw_bytes_q[0].raw;
          void'(raw_bytes_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each accepted word checked against the oldest expectation
  always @(posedge clk) begin
    esc_char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (escape_chars_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", out_byte, out_run_last));
        end else begin
          want = escape_chars_q.pop_front();
          if (out_byte !== want.ch)
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.ch));
          if (out_run_last !== want.last)
            report_mismatch($sformatf("out_run_last %b, expected %b on char %h",
                                      out_run_last, want.last, want.ch));
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] directed [] = {
      RAW_NUL, RAW_BEL, RAW_BS, RAW_TAB, RAW_LF, RAW_VT, RAW_FF, RAW_CR,
      RAW_DQUOTE, RAW_SQUOTE, RAW_BSLASH, PRINT_FIRST, PRINT_LAST,
      8'd31, 8'd127, 8'd1, 8'd6, 8'd15, 8'd14, 8'd16, 8'd128, 8'd255,
      8'd65, 8'd90, 8'd165
    };
    logic [7:0] specials [] = {
      RAW_NUL, RAW_BEL, RAW_BS, RAW_TAB, RAW_LF, RAW_VT, RAW_FF, RAW_CR,
      RAW_DQUOTE, RAW_SQUOTE, RAW_BSLASH, PRINT_FIRST, PRINT_LAST,
      8'd31, 8'd127, 8'd15, 8'd16, 8'd128, 8'd255
    };
    logic [7:0] raw;

    // directed corners first
    foreach (directed[i])
      raw_bytes_q.insert(raw_bytes_q.size(), '{raw: directed[i], wait_empty: 1'b0});

    // random bytes, weighted toward each class of escape
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: raw = 8'($urandom_range(255));
        4, 5:       raw = 8'($urandom_range(31));
        6, 7:       raw = 8'($urandom_range(PRINT_LAST, PRINT_FIRST));
        default:    raw = specials[$urandom_range(specials.size() - 1)];
      endcase
      raw_bytes_q.insert(raw_bytes_q.size(),
                         '{raw: raw, wait_empty: (i == 0) || ($urandom_range(99) < 3)});
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!(raw_bytes_q.size() == 0 && !in_valid && escape_chars_q.size() == 0) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d words still expected", escape_chars_q.size());
      $display("c_escape_encoder regression: fail");
    end else begin
      // let any stray word show up before closing
      repeat (TAIL_CYCLES) @(posedge clk);
      if (error_count == 0) begin
        $display("c_escape_encoder regression: pass");
      end else begin
        $display("c_escape_encoder regression: fail");
      end
    end
    $finish;
  end

endmodule
